[src/psm_pkg.sv]
// ----------------------------------------------------------------------------
// psm_pkg: shared types and constants of the multi-policy task scheduler
// Holds the queue entry layout, command and policy codes and aging helpers.
// ----------------------------------------------------------------------------
package psm_pkg;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] tleft;
    logic [3:0]  prio;
    logic [1:0]  good;
    logic        bad;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [2:0] MODE_ADD_TICK = 3'd0;
  localparam logic [2:0] MODE_ADD      = 3'd1;
  localparam logic [2:0] MODE_TICK     = 3'd2;
  localparam logic [2:0] MODE_WAIT     = 3'd3;
  localparam logic [2:0] MODE_EVENT    = 3'd4;

  localparam logic [2:0] POL_FCFS  = 3'd0;
  localparam logic [2:0] POL_SJF   = 3'd1;
  localparam logic [2:0] POL_RR    = 3'd2;
  localparam logic [2:0] POL_PRIO  = 3'd3;
  localparam logic [2:0] POL_AGING = 3'd4;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_QUANTUM = 2'd1;
  localparam logic [1:0] CFG_LEVELS  = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_WAITING = 2'd2;

  typedef enum logic [1:0] {K_HEAD, K_MIN, K_PRIO, K_ID} scan_kind_t;
  typedef enum logic [1:0] {C_TICK2, C_PICK, C_EVENT} cont_t;

  // Clamp a priority into 1..levels (upper bound 1 when levels is zero).
  function automatic logic [3:0] clamp_prio(logic [4:0] p, logic [3:0] lv);
    logic [4:0] top;
    logic [4:0] r;
    top = (lv == 4'd0) ? 5'd1 : {1'b0, lv};
    r = p;
    if (r < 5'd1) r = 5'd1;
    if (r > top) r = top;
    return r[3:0];
  endfunction

  function automatic entry_t age_requeue(entry_t e, logic [3:0] lv);
    entry_t r;
    r = e;
    r.good = 2'd0;
    if (e.bad) begin
      r.bad = 1'b0;
      r.prio = clamp_prio((e.prio == 4'd0) ? 5'd0 : ({1'b0, e.prio} - 5'd1), lv);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic entry_t age_wait(entry_t e, logic [3:0] lv);
    entry_t r;
    r = e;
    r.bad = 1'b0;
    r.good = (e.good == 2'd3) ? 2'd3 : (e.good + 2'd1);
    if (r.good == 2'd2) r.prio = clamp_prio({1'b0, e.prio} + 5'd1, lv);
    return r;
  endfunction

endpackage

[src/psm_if.sv]
// ----------------------------------------------------------------------------
// psm_if: valid/ready channels of the task scheduler
// Command channel and running-task report channel.
// ----------------------------------------------------------------------------
interface psm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  task_id;
  logic [15:0] task_time;
  logic [3:0]  task_priority;

  modport source (output valid, output mode, output task_id, output task_time,
                  output task_priority, input ready);
  modport sink (input valid, input mode, input task_id, input task_time,
                input task_priority, output ready);
endinterface

interface psm_out_if;
  logic        valid;
  logic        ready;
  logic        running_valid;
  logic [7:0]  running_id;
  logic [15:0] running_left;
  logic [1:0]  status;

  modport source (output valid, output running_valid, output running_id,
                  output running_left, output status, input ready);
  modport sink (input valid, input running_valid, input running_id,
                input running_left, input status, output ready);
endinterface

[src/psm_ram.sv]
// ----------------------------------------------------------------------------
// psm_ram: queue storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psm_ram
  import psm_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/process_scheduler_multi_policy_core.sv]
// ----------------------------------------------------------------------------
// process_scheduler_multi_policy_core: multi-policy task scheduler
// Ready and waiting queues live in two synchronous memories; a sequencer
// walks them to pick, search and compact while one task is running.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  -----------------------------------------------------
//  in_bus    sink       mode, task_id, task_time, task_priority
//  out_bus   source     running_valid, running_id, running_left, status
//  cfg_*     write      cfg_we, cfg_index, cfg_data (policy, quantum, levels)
//
// A tick under a priority policy walks the ready memory once for the best
// priority and, when a pick follows, once more to pick; a pick then compacts
// the queue one entry per cycle through the single memory read port. An event
// first walks the waiting queue, compacting it if the task moves, then ticks.
// Reset is synchronous and active low; the queue memories need no clearing
// since only entries below the fill counts are ever read.
// A result waits in the output register; the next command beat is taken
// while it is held, and the sequencer stalls only when a second result is due.
module process_scheduler_multi_policy_core
  import psm_pkg::*;
#(
  parameter int READY_DEPTH = 16,
  parameter int WAIT_DEPTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  psm_in_if.sink      in_bus,
  psm_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // The ready memory has one spare entry: a requeue appends before it picks.
  localparam int RDEPTH = READY_DEPTH + 1;
  localparam int RAW    = $clog2(RDEPTH);
  localparam int WAW    = $clog2(WAIT_DEPTH);
  localparam int RCW    = $clog2(READY_DEPTH + 2);
  localparam int WCW    = $clog2(WAIT_DEPTH + 1);
  localparam int MAXD   = (READY_DEPTH > WAIT_DEPTH) ? READY_DEPTH : WAIT_DEPTH;
  localparam int CW     = $clog2(MAXD + 2);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EXEC  = 10'b0000000010,
    S_TICK  = 10'b0000000100,
    S_TICK2 = 10'b0000001000,
    S_REQ   = 10'b0000010000,
    S_PICK  = 10'b0000100000,
    S_SCAN  = 10'b0001000000,
    S_SHIFT = 10'b0010000000,
    S_PFIN  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  // Configuration registers.
  logic [2:0]  policy_r;
  logic [15:0] quantum_r;
  logic [3:0]  levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= POL_FCFS;
      quantum_r <= 16'd1;
      levels_r  <= 4'd15;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:  policy_r  <= cfg_data[2:0];
        CFG_QUANTUM: quantum_r <= cfg_data;
        CFG_LEVELS:  levels_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_t      state_r, state_nxt;
  state_t      shift_next_r, shift_next_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  cid_r, cid_nxt;
  logic [15:0] ctime_r, ctime_nxt;
  logic [3:0]  cprio_r, cprio_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [RCW-1:0] rcount_r, rcount_nxt;
  logic [WCW-1:0] wcount_r, wcount_nxt;
  entry_t      run_r, run_nxt;
  logic        run_present_r, run_present_nxt;
  logic [15:0] slice_r, slice_nxt;
  logic [3:0]  high_r, high_nxt;
  logic        req_r, req_nxt;
  logic        qsel_r, qsel_nxt;
  scan_kind_t  kind_r, kind_nxt;
  cont_t       cont_r, cont_nxt;
  logic [CW-1:0] scan_i_r, scan_i_nxt;
  logic        pv_r, pv_nxt;
  logic [CW-1:0] pidx_r, pidx_nxt;
  logic        found_r, found_nxt;
  entry_t      best_r, best_nxt;
  logic [CW-1:0] best_idx_r, best_idx_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic        o_run_r, o_run_nxt;
  logic [7:0]  o_id_r, o_id_nxt;
  logic [15:0] o_left_r, o_left_nxt;
  logic [1:0]  o_status_r, o_status_nxt;

  // Memory ports.
  logic          rq_we, wq_we;
  logic [RAW-1:0] rq_waddr;
  logic [WAW-1:0] wq_waddr;
  entry_t        rq_wdata, wq_wdata, rq_rdata, wq_rdata, rdata;
  logic [CW-1:0] cnt, wr_idx;
  logic          better, elig, slice_pol, prio_pol, in_fire;
  logic [15:0]   t_dec, s_inc;
  entry_t        req_e;

  psm_ram #(.DEPTH(RDEPTH)) u_ready (
    .clk   (clk),
    .we    (rq_we),
    .waddr (rq_waddr),
    .wdata (rq_wdata),
    .raddr (scan_i_r[RAW-1:0]),
    .rdata (rq_rdata)
  );

  psm_ram #(.DEPTH(WAIT_DEPTH)) u_wait (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata (wq_wdata),
    .raddr (scan_i_r[WAW-1:0]),
    .rdata (wq_rdata)
  );

  assign in_bus.ready          = (state_r == S_IDLE);
  assign in_fire               = in_bus.valid && in_bus.ready;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.running_valid = o_run_r;
  assign out_bus.running_id    = o_id_r;
  assign out_bus.running_left  = o_left_r;
  assign out_bus.status        = o_status_r;

  assign cnt    = qsel_r ? CW'(wcount_r) : CW'(rcount_r);
  assign rdata  = qsel_r ? wq_rdata : rq_rdata;
  assign wr_idx = pidx_r - CW'(1);

  assign slice_pol = policy_r inside {POL_RR, POL_PRIO, POL_AGING};
  assign prio_pol  = policy_r inside {POL_PRIO, POL_AGING};
  assign t_dec     = (run_r.tleft != 16'd0) ? (run_r.tleft - 16'd1) : 16'd0;
  assign s_inc     = slice_pol ? (slice_r + 16'd1) : slice_r;
  assign req_e     = (policy_r == POL_AGING) ? age_requeue(run_r, levels_r) : run_r;

  // A lone ready entry is eligible under the priority pick whatever its level.
  assign elig = (cnt == CW'(1)) || (rdata.prio != 4'd0 && rdata.prio <= levels_r);

  always_comb begin
    case (kind_r)
      K_HEAD:  better = !found_r;
      K_MIN:   better = !found_r || (rdata.tleft < best_r.tleft);
      K_PRIO:  better = elig && (!found_r || (rdata.prio > best_r.prio));
      K_ID:    better = !found_r && (rdata.id == cid_r);
      default: better = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    shift_next_nxt  = shift_next_r;
    mode_nxt        = mode_r;
    cid_nxt         = cid_r;
    ctime_nxt       = ctime_r;
    cprio_nxt       = cprio_r;
    status_nxt      = status_r;
    rcount_nxt      = rcount_r;
    wcount_nxt      = wcount_r;
    run_nxt         = run_r;
    run_present_nxt = run_present_r;
    slice_nxt       = slice_r;
    high_nxt        = high_r;
    req_nxt         = req_r;
    qsel_nxt        = qsel_r;
    kind_nxt        = kind_r;
    cont_nxt        = cont_r;
    scan_i_nxt      = scan_i_r;
    pv_nxt          = pv_r;
    pidx_nxt        = pidx_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    best_idx_nxt    = best_idx_r;
    out_valid_nxt   = out_valid_r && !out_bus.ready;
    o_run_nxt       = o_run_r;
    o_id_nxt        = o_id_r;
    o_left_nxt      = o_left_r;
    o_status_nxt    = o_status_r;
    rq_we           = 1'b0;
    rq_waddr        = rcount_r[RAW-1:0];
    rq_wdata        = run_r;
    wq_we           = 1'b0;
    wq_waddr        = wcount_r[WAW-1:0];
    wq_wdata        = run_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_bus.mode;
          cid_nxt    = in_bus.task_id;
          ctime_nxt  = in_bus.task_time;
          cprio_nxt  = in_bus.task_priority;
          status_nxt = ST_OK;
          req_nxt    = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        case (mode_r)
          MODE_ADD_TICK, MODE_ADD: begin
            if (rcount_r >= RCW'(READY_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              rq_we      = 1'b1;
              rq_wdata   = '{id: cid_r, tleft: ctime_r, prio: cprio_r,
                             good: 2'd0, bad: 1'b0};
              rcount_nxt = rcount_r + RCW'(1);
            end
            state_nxt = (mode_r == MODE_ADD_TICK) ? S_TICK : S_OUT;
          end
          MODE_TICK: state_nxt = S_TICK;
          MODE_WAIT: begin
            if (run_present_r) begin
              if (wcount_r >= WCW'(WAIT_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wq_we           = 1'b1;
                wq_wdata        = (policy_r == POL_AGING) ? age_wait(run_r, levels_r)
                                                          : run_r;
                wcount_nxt      = wcount_r + WCW'(1);
                run_present_nxt = 1'b0;
              end
            end
            state_nxt = S_TICK;
          end
          MODE_EVENT: begin
            qsel_nxt   = 1'b1;
            kind_nxt   = K_ID;
            cont_nxt   = C_EVENT;
            scan_i_nxt = '0;
            pv_nxt     = 1'b0;
            found_nxt  = 1'b0;
            state_nxt  = S_SCAN;
          end
          default: state_nxt = S_OUT;
        endcase
      end

      S_TICK: begin
        if (policy_r > POL_AGING) begin
          state_nxt = S_OUT;
        end else if (!run_present_r) begin
          state_nxt = S_PICK;
        end else if (prio_pol) begin
          // Best ready priority is probed before the running task ages.
          qsel_nxt   = 1'b0;
          kind_nxt   = K_PRIO;
          cont_nxt   = C_TICK2;
          scan_i_nxt = '0;
          pv_nxt     = 1'b0;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end else begin
          high_nxt  = 4'd0;
          state_nxt = S_TICK2;
        end
      end

      S_TICK2: begin
        run_nxt.tleft = t_dec;
        slice_nxt     = s_inc;
        if (t_dec == 16'd0) begin
          run_present_nxt = 1'b0;
          state_nxt       = S_PICK;
        end else if (slice_pol &&
                     (s_inc == quantum_r || (prio_pol && run_r.prio < high_r))) begin
          state_nxt = S_REQ;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_REQ: begin
        // The requeued entry stays in run_r in case the pick finds nothing.
        rq_we           = 1'b1;
        rq_wdata        = req_e;
        rcount_nxt      = rcount_r + RCW'(1);
        run_nxt         = req_e;
        run_present_nxt = 1'b0;
        req_nxt         = 1'b1;
        state_nxt       = S_PICK;
      end

      S_PICK: begin
        if (rcount_r == '0) begin
          state_nxt = S_PFIN;
        end else begin
          qsel_nxt   = 1'b0;
          kind_nxt   = (policy_r == POL_SJF) ? K_MIN : (prio_pol ? K_PRIO : K_HEAD);
          cont_nxt   = C_PICK;
          scan_i_nxt = '0;
          pv_nxt     = 1'b0;
          found_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (pv_r && better) begin
          found_nxt    = 1'b1;
          best_nxt     = rdata;
          best_idx_nxt = pidx_r;
        end
        if (scan_i_r < cnt) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = scan_i_r;
          scan_i_nxt = scan_i_r + CW'(1);
        end else begin
          pv_nxt = 1'b0;
        end
        if (!pv_r && scan_i_r >= cnt) begin
          case (cont_r)
            C_TICK2: begin
              high_nxt  = found_r ? best_r.prio : 4'd0;
              state_nxt = S_TICK2;
            end
            C_PICK: begin
              if (found_r) begin
                run_nxt         = best_r;
                run_present_nxt = 1'b1;
                slice_nxt       = 16'd0;
                scan_i_nxt      = best_idx_r + CW'(1);
                pv_nxt          = 1'b0;
                shift_next_nxt  = S_PFIN;
                state_nxt       = S_SHIFT;
              end else begin
                state_nxt = S_PFIN;
              end
            end
            C_EVENT: begin
              if (!found_r) begin
                status_nxt = ST_NOT_WAITING;
                state_nxt  = S_TICK;
              end else if (rcount_r >= RCW'(READY_DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_TICK;
              end else begin
                rq_we          = 1'b1;
                rq_wdata       = best_r;
                rcount_nxt     = rcount_r + RCW'(1);
                scan_i_nxt     = best_idx_r + CW'(1);
                pv_nxt         = 1'b0;
                shift_next_nxt = S_TICK;
                state_nxt      = S_SHIFT;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end

      S_SHIFT: begin
        // Read entry i+1 while the previous beat's data lands at entry i.
        if (pv_r) begin
          if (qsel_r) begin
            wq_we    = 1'b1;
            wq_waddr = wr_idx[WAW-1:0];
            wq_wdata = rdata;
          end else begin
            rq_we    = 1'b1;
            rq_waddr = wr_idx[RAW-1:0];
            rq_wdata = rdata;
          end
        end
        if (scan_i_r < cnt) begin
          pv_nxt     = 1'b1;
          pidx_nxt   = scan_i_r;
          scan_i_nxt = scan_i_r + CW'(1);
        end else begin
          pv_nxt = 1'b0;
        end
        if (!pv_r && scan_i_r >= cnt) begin
          if (qsel_r) begin
            wcount_nxt = wcount_r - WCW'(1);
          end else begin
            rcount_nxt = rcount_r - RCW'(1);
          end
          state_nxt = shift_next_r;
        end
      end

      S_PFIN: begin
        // A requeue into a full queue with nothing picked: the task runs on.
        if (req_r && rcount_r > RCW'(READY_DEPTH)) begin
          rcount_nxt      = rcount_r - RCW'(1);
          run_present_nxt = 1'b1;
          slice_nxt       = 16'd0;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          o_run_nxt     = run_present_r;
          o_id_nxt      = run_present_r ? run_r.id : 8'd0;
          o_left_nxt    = run_present_r ? run_r.tleft : 16'd0;
          o_status_nxt  = status_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rcount_r      <= '0;
      wcount_r      <= '0;
      run_r         <= '0;
      run_present_r <= 1'b0;
      slice_r       <= 16'd0;
      out_valid_r   <= 1'b0;
      req_r         <= 1'b0;
      pv_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rcount_r      <= rcount_nxt;
      wcount_r      <= wcount_nxt;
      run_r         <= run_nxt;
      run_present_r <= run_present_nxt;
      slice_r       <= slice_nxt;
      out_valid_r   <= out_valid_nxt;
      req_r         <= req_nxt;
      pv_r          <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_next_r <= shift_next_nxt;
    mode_r       <= mode_nxt;
    cid_r        <= cid_nxt;
    ctime_r      <= ctime_nxt;
    cprio_r      <= cprio_nxt;
    status_r     <= status_nxt;
    high_r       <= high_nxt;
    qsel_r       <= qsel_nxt;
    kind_r       <= kind_nxt;
    cont_r       <= cont_nxt;
    scan_i_r     <= scan_i_nxt;
    pidx_r       <= pidx_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    o_run_r      <= o_run_nxt;
    o_id_r       <= o_id_nxt;
    o_left_r     <= o_left_nxt;
    o_status_r   <= o_status_nxt;
  end

  // The waiting queue never holds more than its depth.
  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcount_r <= WCW'(WAIT_DEPTH))
    else $error("waiting count beyond depth");

  // The spare ready entry is only used inside a requeue.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> rcount_r <= RCW'(READY_DEPTH))
    else $error("ready count beyond depth between items");

  // An accepted beat always starts the sequencer.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted beat did not start execution");

  // No task running means the reported id and time are zero.
  a_idle_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_run_r |-> o_id_r == 8'd0 && o_left_r == 16'd0)
    else $error("report of an absent task is not zero");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multi-policy task scheduler
// Drives command beats under every policy and several quantum and level
// settings, predicts each running-task report and compares it field by field.
// ----------------------------------------------------------------------------

// One expected running-task report.
typedef struct {
  logic        run_on;
  logic [7:0]  run_id;
  logic [15:0] run_left;
  logic [1:0]  st;
} sched_report_t;

// Scheduler predictor together with the queue of reports it expects.
class sched_scoreboard;
  psm_pkg::entry_t rdy_q[17];
  int              rdy_n;
  psm_pkg::entry_t wait_q[16];
  int              wait_n;
  psm_pkg::entry_t cur;
  bit              cur_on;
  logic [15:0]     slice;
  logic [2:0]      pol;
  logic [15:0]     quant;
  logic [3:0]      lvls;
  sched_report_t   pending[$];
  int              errors;

  function void clear();
    rdy_n = 0; wait_n = 0; cur = '0; cur_on = 0; slice = '0;
    pol = psm_pkg::POL_FCFS; quant = 16'd1; lvls = 4'd15;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == psm_pkg::CFG_POLICY) pol = val[2:0];
    else if (idx == psm_pkg::CFG_QUANTUM) quant = val;
    else if (idx == psm_pkg::CFG_LEVELS) lvls = val[3:0];
  endfunction

  function logic [3:0] limit_prio(int p);
    int top;
    top = (lvls < 1) ? 1 : int'(lvls);
    if (p < 1) p = 1;
    if (p > top) p = top;
    return p[3:0];
  endfunction

  function void drop_ready(int idx);
    for (int i = idx; i + 1 < rdy_n; i++) rdy_q[i] = rdy_q[i + 1];
    rdy_n--;
  endfunction

  // Index of the first entry at the highest searched level; a lone entry
  // is always chosen whatever its priority.
  function int top_prio_slot();
    if (rdy_n == 0) return -1;
    if (rdy_n == 1) return 0;
    for (int lv = lvls; lv >= 1; lv--)
      for (int i = 0; i < rdy_n; i++)
        if (rdy_q[i].prio == lv) return i;
    return -1;
  endfunction

  function void choose_next();
    int idx;
    if (rdy_n == 0) return;
    idx = 0;
    if (pol == psm_pkg::POL_SJF) begin
      for (int i = 1; i < rdy_n; i++)
        if (rdy_q[i].tleft < rdy_q[idx].tleft) idx = i;
    end else if (pol >= psm_pkg::POL_PRIO) begin
      idx = top_prio_slot();
    end
    if (idx < 0) return;
    cur = rdy_q[idx];
    drop_ready(idx);
    cur_on = 1;
    slice = '0;
  endfunction

  function void preempt();
    psm_pkg::entry_t e;
    e = cur;
    if (pol == psm_pkg::POL_AGING) begin
      e.good = 2'd0;
      if (e.bad) begin
        e.prio = limit_prio(int'(e.prio) - 1);
        e.bad = 1'b0;
      end else begin
        e.bad = 1'b1;
      end
    end
    rdy_q[rdy_n] = e;
    rdy_n++;
    cur_on = 0;
    choose_next();
    // Nothing was taken out, so the preempted task keeps the processor.
    if (rdy_n > 16) begin
      rdy_n--;
      cur = rdy_q[rdy_n];
      cur_on = 1;
      slice = '0;
    end
  endfunction

  function void advance();
    int high;
    if (pol > psm_pkg::POL_AGING) return;
    if (!cur_on) begin
      choose_next();
      return;
    end
    high = 0;
    if (pol >= psm_pkg::POL_PRIO) begin
      int k;
      k = top_prio_slot();
      high = (k < 0) ? 0 : int'(rdy_q[k].prio);
    end
    if (cur.tleft > 0) cur.tleft--;
    if (pol >= psm_pkg::POL_RR) slice++;
    if (cur.tleft == 0) begin
      cur_on = 0;
      choose_next();
      return;
    end
    if (pol >= psm_pkg::POL_RR &&
        (slice == quant || (pol >= psm_pkg::POL_PRIO && int'(cur.prio) < high)))
      preempt();
  endfunction

  function void note_input(logic [2:0] mode, logic [7:0] id, logic [15:0] t,
                           logic [3:0] p);
    sched_report_t r;
    psm_pkg::entry_t e;
    int hit;
    r.st = psm_pkg::ST_OK;
    if (mode == psm_pkg::MODE_ADD_TICK || mode == psm_pkg::MODE_ADD) begin
      if (rdy_n >= 16) begin
        r.st = psm_pkg::ST_FULL;
      end else begin
        e.id = id; e.tleft = t; e.prio = p; e.good = 2'd0; e.bad = 1'b0;
        rdy_q[rdy_n] = e;
        rdy_n++;
      end
      if (mode == psm_pkg::MODE_ADD_TICK) advance();
    end else if (mode == psm_pkg::MODE_TICK) begin
      advance();
    end else if (mode == psm_pkg::MODE_WAIT) begin
      if (cur_on) begin
        if (wait_n >= 16) begin
          r.st = psm_pkg::ST_FULL;
        end else begin
          e = cur;
          if (pol == psm_pkg::POL_AGING) begin
            e.bad = 1'b0;
            e.good = (e.good == 2'd3) ? 2'd3 : e.good + 2'd1;
            if (e.good == 2'd2) e.prio = limit_prio(int'(e.prio) + 1);
          end
          wait_q[wait_n] = e;
          wait_n++;
          cur_on = 0;
        end
      end
      advance();
    end else if (mode == psm_pkg::MODE_EVENT) begin
      hit = -1;
      for (int i = 0; i < wait_n; i++)
        if (hit < 0 && wait_q[i].id == id) hit = i;
      if (hit < 0) begin
        r.st = psm_pkg::ST_NOT_WAITING;
      end else if (rdy_n >= 16) begin
        r.st = psm_pkg::ST_FULL;
      end else begin
        rdy_q[rdy_n] = wait_q[hit];
        rdy_n++;
        for (int i = hit; i + 1 < wait_n; i++) wait_q[i] = wait_q[i + 1];
        wait_n--;
      end
      advance();
    end
    r.run_on = cur_on;
    r.run_id = cur_on ? cur.id : 8'd0;
    r.run_left = cur_on ? cur.tleft : 16'd0;
    pending.push_back(r);
  endfunction

  function void check_result(logic rv, logic [7:0] id, logic [15:0] left,
                             logic [1:0] st);
    sched_report_t x;
    if (pending.size() == 0) begin
      $display("%0t: report with nothing expected: valid %0d id %0d left %0d status %0d",
               $time, rv, id, left, st);
      errors++;
      return;
    end
    x = pending.pop_front();
    if (rv !== x.run_on) begin
      $display("%0t: running_valid expected %0d actual %0d", $time, x.run_on, rv);
      errors++;
    end
    if (id !== x.run_id) begin
      $display("%0t: running_id expected %0d actual %0d", $time, x.run_id, id);
      errors++;
    end
    if (left !== x.run_left) begin
      $display("%0t: running_left expected %0d actual %0d", $time, x.run_left, left);
      errors++;
    end
    if (st !== x.st) begin
      $display("%0t: status expected %0d actual %0d", $time, x.st, st);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import psm_pkg::*;

  // Show has no code of its own in the package; unknown modes act like it.
  localparam logic [2:0] MODE_SHOW = 3'd5;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  psm_in_if  in_bus();
  psm_out_if out_bus();

  process_scheduler_multi_policy_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sched_scoreboard sb;

  // Idle pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both, lightly.
  int idle_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // The receiver stalls at random according to the current idle pattern.
  always @(posedge clk) begin
    if (idle_phase == 2) out_bus.ready <= ($urandom_range(0, 99) >= 57);
    else if (idle_phase == 3) out_bus.ready <= ($urandom_range(0, 99) >= 7);
    else out_bus.ready <= 1'b1;
  end

  // Input and output monitors sample the handshake as it stood at the edge.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_input(in_bus.mode, in_bus.task_id, in_bus.task_time, in_bus.task_priority);
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.running_valid, out_bus.running_id,
                      out_bus.running_left, out_bus.status);
  end

  // Present one command beat, with a random gap in front of it, and hold it
  // until the block takes it.
  task automatic send_cmd(logic [2:0] mode, logic [7:0] id, logic [15:0] t,
                          logic [3:0] p);
    int gap_pct;
    gap_pct = (idle_phase == 1) ? 57 : (idle_phase == 3) ? 7 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= mode;
    in_bus.task_id       <= id;
    in_bus.task_time     <= t;
    in_bus.task_priority <= p;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Let every outstanding report drain, then allow the sequencer to settle.
  task automatic drain_reports();
    in_bus.valid <= 1'b0;
    for (int n = 0; n < 400000 && sb.pending.size() != 0; n++) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("Mismatches found");
      $finish;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_policy(logic [2:0] pol, logic [15:0] q, logic [3:0] lv);
    drain_reports();
    write_reg(CFG_POLICY, {13'd0, pol});
    write_reg(CFG_QUANTUM, q);
    write_reg(CFG_LEVELS, {12'd0, lv});
  endtask

  // Mostly short run times so tasks finish and the queues churn; now and
  // then the full range, zero included.
  function automatic logic [15:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(1, 12));
    if (r < 85) return 16'd0;
    if (r < 90) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, 15));
    return 8'($urandom);
  endfunction

  // Release an id that is actually waiting, most of the time.
  function automatic logic [7:0] waiting_id();
    if (sb.wait_n > 0 && $urandom_range(0, 9) < 8)
      return sb.wait_q[$urandom_range(0, sb.wait_n - 1)].id;
    return pick_id();
  endfunction

  // One random sequence: a lone random beat, or a burst of adds that can fill
  // the ready queue, a burst of waits with some add-ticks, or a burst of event releases.
  task automatic random_burst(output int beats);
    int kind;
    int len;
    logic [2:0] m;
    kind = $urandom_range(0, 99);
    beats = 0;
    if (kind < 55) begin
      m = 3'($urandom_range(0, 99) < 3 ? $urandom_range(6, 7) : $urandom_range(0, 5));
      if (m == MODE_EVENT) send_cmd(m, waiting_id(), pick_time(), 4'($urandom));
      else send_cmd(m, pick_id(), pick_time(), 4'($urandom));
      beats = 1;
    end else if (kind < 75) begin
      len = $urandom_range(3, 18);
      for (int i = 0; i < len; i++)
        send_cmd($urandom_range(0, 1) ? MODE_ADD : MODE_ADD_TICK, pick_id(),
                 pick_time(), 4'($urandom));
      beats = len;
    end else if (kind < 88) begin
      len = $urandom_range(2, 17);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_cmd(MODE_ADD_TICK, pick_id(), pick_time(), 4'($urandom));
        else
          send_cmd(MODE_WAIT, pick_id(), pick_time(), 4'($urandom));
      end
      beats = len;
    end else begin
      len = $urandom_range(2, 17);
      for (int i = 0; i < len; i++)
        send_cmd(MODE_EVENT, waiting_id(), pick_time(), 4'($urandom));
      beats = len;
    end
  endtask

  // Policy, quantum and level settings visited in turn; the later entries
  // cover a zero quantum, zero levels and the unknown policies.
  logic [2:0]  set_pol[12] = '{POL_FCFS, POL_SJF, POL_RR, POL_RR, POL_PRIO, POL_PRIO,
                                POL_AGING, POL_AGING, POL_AGING, POL_RR, 3'd5, 3'd7};
  logic [15:0] set_q[12]   = '{16'd1, 16'd1, 16'd1, 16'd3, 16'd2, 16'hFFFF,
                                16'd2, 16'd1, 16'd5, 16'd0, 16'd4, 16'd1};
  logic [3:0]  set_lv[12]  = '{4'd15, 4'd15, 4'd15, 4'd7, 4'd15, 4'd1,
                                4'd15, 4'd0, 4'd8, 4'd15, 4'd15, 4'd15};

  initial begin
    int done_beats;
    int n;
    sb = new();
    sb.clear();
    idle_phase = 0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_POLICY;
    cfg_data             <= 16'd0;
    in_bus.valid         <= 1'b0;
    in_bus.mode          <= MODE_SHOW;
    in_bus.task_id       <= 8'd0;
    in_bus.task_time     <= 16'd0;
    in_bus.task_priority <= 4'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset settings: empty scheduler, field
    // extremes, zero run time, unknown event id, unknown modes.
    send_cmd(MODE_SHOW, 8'd0, 16'd1, 4'd0);
    send_cmd(MODE_TICK, 8'd0, 16'd1, 4'd0);
    send_cmd(MODE_WAIT, 8'd0, 16'd1, 4'd0);
    send_cmd(MODE_EVENT, 8'd77, 16'd1, 4'd0);
    send_cmd(MODE_ADD_TICK, 8'd255, 16'hFFFF, 4'd15);
    send_cmd(MODE_ADD, 8'd0, 16'd0, 4'd0);
    send_cmd(MODE_ADD, 8'd1, 16'd1, 4'd7);
    send_cmd(MODE_WAIT, 8'd0, 16'd0, 4'd0);
    send_cmd(MODE_TICK, 8'd0, 16'd0, 4'd0);
    send_cmd(MODE_TICK, 8'd0, 16'd0, 4'd0);
    send_cmd(MODE_EVENT, 8'd255, 16'd0, 4'd0);
    send_cmd(MODE_EVENT, 8'd255, 16'd0, 4'd0);
    send_cmd(3'd6, 8'hAA, 16'h5555, 4'd5);
    send_cmd(3'd7, 8'h55, 16'hAAAA, 4'd10);
    for (int i = 0; i < 8; i++)
      send_cmd(MODE_ADD, 8'(i + 2), 16'(i + 1), 4'(i));
    send_cmd(MODE_SHOW, 8'd0, 16'd1, 4'd0);

    // Random part: each setting gets its share, the idle pattern rotates.
    n = 0;
    for (int s = 0; s < 12; s++) begin
      set_policy(set_pol[s], set_q[s], set_lv[s]);
      done_beats = 0;
      while (done_beats < 160) begin
        int b;
        if ((n / 40) % 4 != idle_phase) idle_phase = (n / 40) % 4;
        random_burst(b);
        done_beats += b;
        n += b;
      end
    end

    drain_reports();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[filelist.f]
src/psm_pkg.sv
src/psm_if.sv
src/psm_ram.sv
src/process_scheduler_multi_policy_core.sv
test/tb_top.sv
